/* src/lppe_pkg.sv */
// ----------------------------------------------------------------------------
// lppe_pkg
// Shared types, constants and the pattern expansion function of the LED
// pixel pulse pattern encoder.
// ----------------------------------------------------------------------------
package lppe_pkg;

  localparam int BYTE_W     = 8;
  localparam int COL_W      = 8;
  localparam int PIX_BITS   = 3 * COL_W;
  localparam int PAT_W      = 10;
  localparam int CNT_W      = 5;
  localparam int STREAM_W   = PIX_BITS * PAT_W;
  localparam int PIX_BYTES  = STREAM_W / BYTE_W;
  localparam int DCNT_W     = $clog2(PIX_BYTES);
  localparam int IN_DATA_W  = PIX_BITS;

  localparam int MAX_RESET_BYTES_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = PAT_W;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_PATTERN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PATTERN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_COUNT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_COUNT  = CFG_IDX_W'(3);

  localparam logic [PAT_W-1:0] ONE_PATTERN_RST  = PAT_W'(1008);
  localparam logic [PAT_W-1:0] ZERO_PATTERN_RST = PAT_W'(896);
  localparam logic [CNT_W-1:0] LEAD_COUNT_RST   = CNT_W'(8);
  localparam logic [CNT_W-1:0] TRAIL_COUNT_RST  = CNT_W'(8);

  typedef struct packed {
    logic [PAT_W-1:0] one_pattern;
    logic [PAT_W-1:0] zero_pattern;
    logic [CNT_W-1:0] lead_count;
    logic [CNT_W-1:0] trail_count;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

  // The colour word holds green in the top byte, so bit k of it maps to the
  // pattern slot k of the stream and the stream goes out from its top bit.
  function automatic logic [STREAM_W-1:0] expand_pixel(
    input logic [PIX_BITS-1:0] grb,
    input logic [PAT_W-1:0]    one_pat,
    input logic [PAT_W-1:0]    zero_pat
  );
    logic [STREAM_W-1:0] s;
    s = '0;
    for (int k = 0; k < PIX_BITS; k++) begin
      s[k*PAT_W +: PAT_W] = grb[k] ? one_pat : zero_pat;
    end
    return s;
  endfunction

endpackage

/* src/lppe_front.sv */
// ----------------------------------------------------------------------------
// lppe_front
// Accepts pixels, decides the leading and trailing zero runs of each and
// tracks whether a frame is open.
// ----------------------------------------------------------------------------
module lppe_front #(
  parameter int MAX_RESET_BYTES = lppe_pkg::MAX_RESET_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lppe_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  input  lppe_pkg::cfg_t                     cfg,
  output logic                               q_valid,
  input  logic                               q_ready,
  output logic [lppe_pkg::PIX_BITS+2*($clog2(MAX_RESET_BYTES+2))-1:0] q_data
);

  localparam int RC_W = $clog2(MAX_RESET_BYTES + 2);

  logic            frame_open_r;
  logic [RC_W-1:0] lead_clamp;
  logic [RC_W-1:0] trail_clamp;
  logic [RC_W-1:0] lead_run;
  logic [RC_W-1:0] trail_run;
  logic [lppe_pkg::PIX_BITS-1:0] grb;

  always_comb begin
    lead_clamp  = (cfg.lead_count > lppe_pkg::CNT_W'(MAX_RESET_BYTES)) ?
                  RC_W'(MAX_RESET_BYTES) : cfg.lead_count[RC_W-1:0];
    trail_clamp = (cfg.trail_count > lppe_pkg::CNT_W'(MAX_RESET_BYTES)) ?
                  RC_W'(MAX_RESET_BYTES) : cfg.trail_count[RC_W-1:0];
    lead_run    = frame_open_r ? '0 : lead_clamp;
    trail_run   = in_tlast ? trail_clamp : '0;
    // Green, red, blue from the top down.
    grb         = {in_tdata[15:8], in_tdata[7:0], in_tdata[23:16]};
  end

  assign q_valid   = in_tvalid;
  assign in_tready = q_ready;
  assign q_data    = {trail_run, lead_run, grb};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
    end else if (in_tvalid && q_ready) begin
      frame_open_r <= !in_tlast;
    end
  end

endmodule

/* src/lppe_queue.sv */
// ----------------------------------------------------------------------------
// lppe_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module lppe_queue #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         push;
  logic         pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* src/lppe_back.sv */
// ----------------------------------------------------------------------------
// lppe_back
// Sequencer that turns one queued pixel into its leading zeros, its 30
// pattern bytes and its trailing zeros, one byte per cycle into the output
// register whenever the output is not stalled by out_tready.
// ----------------------------------------------------------------------------
module lppe_back #(
  parameter int MAX_RESET_BYTES = lppe_pkg::MAX_RESET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lppe_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic [lppe_pkg::PIX_BITS+2*($clog2(MAX_RESET_BYTES+2))-1:0] q_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lppe_pkg::BYTE_W-1:0]    out_tdata,
  output logic                           out_tlast,
  output lppe_pkg::bk_stat_t             stat
);

  localparam int RC_W = $clog2(MAX_RESET_BYTES + 2);
  localparam int SW   = lppe_pkg::STREAM_W;
  localparam int BW   = lppe_pkg::BYTE_W;
  localparam int DW   = lppe_pkg::DCNT_W;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;

  logic            cur_valid_r, cur_valid_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [RC_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   dcnt_r, dcnt_nxt;
  logic [RC_W-1:0] trail_r, trail_nxt;
  logic [SW-1:0]   sh_r, sh_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [BW-1:0]   out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;

  logic            advance;
  logic            emit;
  logic            fin;
  logic            beat_last;
  logic [BW-1:0]   beat_byte;
  logic            pop;
  logic            data_end;

  logic [lppe_pkg::PIX_BITS-1:0] q_grb;
  logic [RC_W-1:0] q_lead;
  logic [RC_W-1:0] q_trail;

  assign {q_trail, q_lead, q_grb} = q_data;

  always_comb begin
    advance  = !out_valid_r || out_tready;
    emit     = advance && cur_valid_r;
    data_end = (dcnt_r == DW'(lppe_pkg::PIX_BYTES - 1));
    unique case (phase_r)
      PH_LEAD: begin
        beat_byte = '0;
        fin       = 1'b0;
      end
      PH_DATA: begin
        beat_byte = sh_r[SW-1 -: BW];
        fin       = data_end && (trail_r == '0);
      end
      PH_TRAIL: begin
        beat_byte = '0;
        fin       = (cnt_r == RC_W'(1));
      end
      default: begin
        beat_byte = '0;
        fin       = 1'b0;
      end
    endcase
    beat_last = fin;
    pop       = q_valid && (!cur_valid_r || (emit && fin));
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    trail_nxt     = trail_r;
    sh_nxt        = sh_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (emit) begin
      unique case (phase_r)
        PH_LEAD: begin
          cnt_nxt = cnt_r - RC_W'(1);
          if (cnt_r == RC_W'(1)) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          sh_nxt   = {sh_r[SW-BW-1:0], {BW{1'b0}}};
          dcnt_nxt = dcnt_r + DW'(1);
          if (data_end && (trail_r != '0)) begin
            phase_nxt = PH_TRAIL;
            cnt_nxt   = trail_r;
          end
        end
        PH_TRAIL: begin
          cnt_nxt = cnt_r - RC_W'(1);
        end
        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase
      if (fin) begin
        cur_valid_nxt = 1'b0;
      end
    end

    // A new pixel loads in the same cycle as the previous one's final beat.
    if (pop) begin
      cur_valid_nxt = 1'b1;
      phase_nxt     = (q_lead != '0) ? PH_LEAD : PH_DATA;
      cnt_nxt       = q_lead;
      dcnt_nxt      = '0;
      trail_nxt     = q_trail;
      sh_nxt        = lppe_pkg::expand_pixel(q_grb, cfg.one_pattern, cfg.zero_pattern);
    end

    if (advance) begin
      out_valid_nxt = emit;
      out_data_nxt  = beat_byte;
      out_last_nxt  = beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= PH_LEAD;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trail_r    <= trail_nxt;
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign q_ready    = pop;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign stat.busy  = cur_valid_r;
  assign stat.pop   = pop;

endmodule

/* src/led_pixel_pulse_pattern_encoder.sv */
// ----------------------------------------------------------------------------
// Path: a pixel passes the queue, the sequencer's pixel registers and the
// output register. Throughput: one output byte per cycle while out_tready
// is high; a pixel gives 30 bytes plus its leading and trailing zero runs.
// The input fills a two-entry queue while a pixel drains, until it is full.
// Reset: synchronous, active low; registers return to defaults, the frame is
// closed and the queue and output register are empty.
// ----------------------------------------------------------------------------
// led_pixel_pulse_pattern_encoder
// Turns RGB pixels into the SPI byte stream of a serial LED chain.
// ----------------------------------------------------------------------------
module led_pixel_pulse_pattern_encoder #(
  parameter int MAX_RESET_BYTES = lppe_pkg::MAX_RESET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lppe_pkg::IN_DATA_W-1:0]    in_tdata,   // red, green, blue
  input  logic                              in_tlast,   // last_pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lppe_pkg::BYTE_W-1:0]       out_tdata,  // spi_byte
  output logic                              out_tlast,  // run_last
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lppe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lppe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int RC_W    = $clog2(MAX_RESET_BYTES + 2);
  localparam int ENTRY_W = lppe_pkg::PIX_BITS + 2 * RC_W;

  lppe_pkg::cfg_t     cfg_r;
  lppe_pkg::bk_stat_t bk_stat;

  logic               fq_valid;
  logic               fq_ready;
  logic [ENTRY_W-1:0] fq_data;
  logic               qb_valid;
  logic               qb_ready;
  logic [ENTRY_W-1:0] qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_pattern  <= lppe_pkg::ONE_PATTERN_RST;
      cfg_r.zero_pattern <= lppe_pkg::ZERO_PATTERN_RST;
      cfg_r.lead_count   <= lppe_pkg::LEAD_COUNT_RST;
      cfg_r.trail_count  <= lppe_pkg::TRAIL_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lppe_pkg::REG_ONE_PATTERN:  cfg_r.one_pattern  <= cfg_data;
        lppe_pkg::REG_ZERO_PATTERN: cfg_r.zero_pattern <= cfg_data;
        lppe_pkg::REG_LEAD_COUNT:   cfg_r.lead_count   <= cfg_data[lppe_pkg::CNT_W-1:0];
        lppe_pkg::REG_TRAIL_COUNT:  cfg_r.trail_count  <= cfg_data[lppe_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lppe_front #(
    .MAX_RESET_BYTES(MAX_RESET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  lppe_queue #(
    .W(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  lppe_back #(
    .MAX_RESET_BYTES(MAX_RESET_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (bk_stat)
  );

`ifndef ASSERT_OFF
  // With no pixel in the sequencer, a taken beat is not followed by another.
  a_idle_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!bk_stat.busy && out_tvalid && out_tready) |=> !out_tvalid)
    else $error("output beat produced while the sequencer was idle");

  // The sequencer only takes a pixel that the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> qb_valid)
    else $error("sequencer popped an empty queue");

  // The sequencer goes idle only right after loading a pixel's final beat.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(bk_stat.busy) && $past(rst_n)) |-> (out_tvalid && out_tlast))
    else $error("sequencer went idle without a final beat");
`endif

endmodule

/* sim/led_pixel_pulse_pattern_encoder_tb.sv */
// ----------------------------------------------------------------------------
// led_pixel_pulse_pattern_encoder_tb
// Sends RGB pixels into the encoder and checks every SPI byte against a
// local prediction of the pulse-pattern stream. The prediction covers the
// leading and trailing zero runs and the run_last flag. Register settings
// change between traffic phases, and the two sides idle and stall at
// different rates in each phase.
// ----------------------------------------------------------------------------
module led_pixel_pulse_pattern_encoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lppe_pkg::*;

  // Register indexes that the block does not decode. Writes to them must be
  // dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = CFG_IDX_W'(15);

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_HALF    = 43;

  typedef struct {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] spi_byte;
    logic              run_last;
  } spi_beat_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // red, green, blue
  logic                  in_tlast   = 1'b0; // last_pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;         // spi_byte
  logic                  out_tlast;         // run_last
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  pixel_t    pixel_q[$];
  spi_beat_t spi_expect_q[$];

  // Shadow copy of the block's registers and frame state.
  logic [PAT_W-1:0] one_pat_m     = ONE_PATTERN_RST;
  logic [PAT_W-1:0] zero_pat_m    = ZERO_PATTERN_RST;
  logic [CNT_W-1:0] lead_cnt_m    = LEAD_COUNT_RST;
  logic [CNT_W-1:0] trail_cnt_m   = TRAIL_COUNT_RST;
  logic             frame_open_m  = 1'b0;

  logic in_fire        = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   errors         = 0;

  led_pixel_pulse_pattern_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int sat_count(input logic [CNT_W-1:0] c);
    return (c > MAX_RESET_BYTES_DEF) ? MAX_RESET_BYTES_DEF : int'(c);
  endfunction

  // Expands one pixel into the expected SPI bytes. Colour bits go out green
  // first, MSB first, each as a 10-bit pattern packed MSB first.
  task automatic predict_spi_bytes(input logic [COL_W-1:0] r, input logic [COL_W-1:0] g,
                                   input logic [COL_W-1:0] b, input logic last);
    logic [PIX_BITS-1:0] grb;
    logic [STREAM_W-1:0] stream;
    int                  n_lead;
    int                  n_trail;
    grb    = {g, r, b};
    stream = '0;
    for (int k = PIX_BITS - 1; k >= 0; k--) begin
      stream = {stream[STREAM_W-PAT_W-1:0], grb[k] ? one_pat_m : zero_pat_m};
    end
    n_lead  = frame_open_m ? 0 : sat_count(lead_cnt_m);
    n_trail = last ? sat_count(trail_cnt_m) : 0;
    for (int i = 0; i < n_lead; i++) begin
      spi_expect_q.push_back(spi_beat_t'{spi_byte: '0, run_last: 1'b0});
    end
    for (int j = 0; j < PIX_BYTES; j++) begin
      spi_expect_q.push_back(spi_beat_t'{spi_byte: stream[STREAM_W-1-BYTE_W*j -: BYTE_W],
                                         run_last: (j == PIX_BYTES - 1) && (n_trail == 0)});
    end
    for (int i = 0; i < n_trail; i++) begin
      spi_expect_q.push_back(spi_beat_t'{spi_byte: '0, run_last: i == n_trail - 1});
    end
    frame_open_m = !last;
  endtask

  always @(negedge clk) begin : pixel_driver
    pixel_t pix;
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pix = pixel_q.pop_front();
        in_tdata  <= {pix.blue, pix.green, pix.red};
        in_tlast  <= pix.last_pixel;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : spi_monitor
    spi_beat_t want;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_spi_bytes(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (spi_expect_q.size() == 0) begin
          $error("unexpected SPI beat: spi_byte %02h run_last %0b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = spi_expect_q.pop_front();
          if (out_tdata !== want.spi_byte) begin
            $error("spi_byte: expected %02h, got %02h", want.spi_byte, out_tdata);
            errors++;
          end
          if (out_tlast !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ONE_PATTERN:  one_pat_m   = val[PAT_W-1:0];
      REG_ZERO_PATTERN: zero_pat_m  = val[PAT_W-1:0];
      REG_LEAD_COUNT:   lead_cnt_m  = val[CNT_W-1:0];
      REG_TRAIL_COUNT:  trail_cnt_m = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic last);
    pixel_q.push_back('{red: r, green: g, blue: b, last_pixel: last});
  endtask

  // Waits until every pixel is taken and every SPI byte has come out, then
  // lets the back end settle.
  task automatic drain_all();
    @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || spi_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pattern();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom_range(1023));
    endcase
  endfunction

  // Mostly short zero runs to keep the run fast, with the edges and
  // oversized values now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_RESET_BYTES_DEF);
      2:       return CFG_DATA_W'($urandom_range(1023, MAX_RESET_BYTES_DEF + 1));
      default: return CFG_DATA_W'($urandom_range(6));
    endcase
  endfunction

  task automatic queue_frames(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        add_pixel(pick_colour(), pick_colour(), pick_colour(), i == len - 1);
      end
      left -= len;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(REG_ONE_PATTERN, pick_pattern());
    write_reg(REG_ZERO_PATTERN, pick_pattern());
    write_reg(REG_LEAD_COUNT, pick_count());
    write_reg(REG_TRAIL_COUNT, pick_count());
    write_reg(CFG_IDX_W'($urandom_range(15, 4)), CFG_DATA_W'($urandom_range(1023)));
    queue_frames(PHASE_HALF);
    // Leave a frame open so the next register write lands inside it.
    add_pixel(pick_colour(), pick_colour(), pick_colour(), 1'b0);
    drain_all();
    case ($urandom_range(3))
      0:       write_reg(REG_ONE_PATTERN, pick_pattern());
      1:       write_reg(REG_ZERO_PATTERN, pick_pattern());
      2:       write_reg(REG_LEAD_COUNT, pick_count());
      default: write_reg(REG_TRAIL_COUNT, pick_count());
    endcase
    queue_frames(PHASE_HALF);
    drain_all();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default registers: full frame with leading and trailing runs.
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_pixel(8'hAA, 8'h55, 8'h0F, 1'b1);
    drain_all();

    // No zero runs at all, then a pattern swap in the middle of a frame.
    write_reg(REG_ONE_PATTERN, 10'h3FF);
    write_reg(REG_ZERO_PATTERN, 10'h000);
    write_reg(REG_LEAD_COUNT, 10'd0);
    write_reg(REG_TRAIL_COUNT, 10'd0);
    add_pixel(8'h80, 8'h01, 8'hFF, 1'b1);
    add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    drain_all();
    write_reg(REG_ONE_PATTERN, 10'h000);
    write_reg(REG_ZERO_PATTERN, 10'h3FF);
    add_pixel(8'h5A, 8'hC3, 8'h3C, 1'b1);
    drain_all();

    // Counts above the limit saturate; the upper data bits are dropped.
    write_reg(REG_LEAD_COUNT, 10'h3F1);
    write_reg(REG_TRAIL_COUNT, 10'd31);
    write_reg(REG_ONE_PATTERN, 10'h155);
    write_reg(REG_ZERO_PATTERN, 10'h2AA);
    add_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    drain_all();

    // Writes to undecoded indexes must change nothing.
    write_reg(REG_NONE_LO, 10'h3FF);
    write_reg(REG_NONE_HI, 10'h000);
    add_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    add_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
    drain_all();

    // Longest possible pixel: both runs at the limit.
    write_reg(REG_LEAD_COUNT, 10'd16);
    write_reg(REG_TRAIL_COUNT, 10'd16);
    add_pixel(8'hF0, 8'h0F, 8'h99, 1'b1);
    drain_all();

    write_reg(REG_LEAD_COUNT, 10'd1);
    write_reg(REG_TRAIL_COUNT, 10'd0);
    add_pixel(8'h7F, 8'hFE, 8'h01, 1'b0);
    add_pixel(8'h80, 8'h00, 8'hFF, 1'b1);
    drain_all();

    run_phase(0, 0);
    run_phase(75, 0);
    run_phase(0, 75);
    run_phase(33, 33);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
